>>> hdl/dtq_pkg.sv
package dtq_pkg;

  localparam int Capacity = 128;
  localparam int IdWidth  = 16;
  localparam int CntWidth = $clog2(Capacity + 1);

  localparam logic [2:0] MODE_ADD      = 3'd0;
  localparam logic [2:0] MODE_DELETE   = 3'd1;
  localparam logic [2:0] MODE_COMPLETE = 3'd2;
  localparam logic [2:0] MODE_UNDO     = 3'd3;
  localparam logic [2:0] MODE_PEEK     = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_DATE  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_NO_IDS    = 3'd5;

  // one stored task
  typedef struct packed {
    logic [IdWidth-1:0] id;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
  } entry_t;

  // operation broadcast to every cell of one row
  typedef enum logic [2:0] {
    OP_HOLD, OP_INSERT, OP_DELETE, OP_POP_FRONT, OP_PUSH_BACK, OP_POP_BACK
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } row_cmd_t;

  function automatic logic [22:0] date_key(input entry_t e);
    date_key = {e.year, e.month, e.day};
  endfunction

endpackage

>>> hdl/dtq_cell.sv
module dtq_cell
  import dtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  row_cmd_t cmd,
  input  entry_t   left_ent,
  input  logic     left_hit,
  input  logic     left_gt,
  input  logic     right_occ,
  input  entry_t   right_ent,
  input  logic     left_fill,
  output logic     occ,
  output entry_t   ent,
  output logic     hit,
  output logic     gt,
  output logic     fill
);

  logic   occ_r, occ_nxt;
  entry_t ent_r, ent_nxt;
  logic   hit_seen;

  // local compares against the broadcast entry
  assign hit  = occ_r && (ent_r.id == cmd.ent.id);
  assign gt   = occ_r && (date_key(ent_r) > date_key(cmd.ent));
  assign fill = occ_r;
  // a match somewhere at or left of this cell
  assign hit_seen = left_hit || hit;

  always_comb begin
    occ_nxt = occ_r;
    ent_nxt = ent_r;
    case (cmd.op)
      OP_INSERT: begin
        // cells past the insert point, up to the first free one, take the left neighbor
        if (left_gt && (gt || !occ_r)) begin
          ent_nxt = left_ent;
          occ_nxt = 1'b1;
        end else if (gt || (!occ_r && left_fill)) begin
          ent_nxt = cmd.ent;
          occ_nxt = 1'b1;
        end
      end
      OP_DELETE: begin
        if (hit_seen) begin
          ent_nxt = right_ent;
          occ_nxt = right_occ;
        end
      end
      OP_POP_FRONT: begin
        ent_nxt = right_ent;
        occ_nxt = right_occ;
      end
      OP_PUSH_BACK: begin
        if (!occ_r && left_fill) begin
          ent_nxt = cmd.ent;
          occ_nxt = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (occ_r && !right_occ) occ_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    ent_r <= ent_nxt;
  end

  assign occ = occ_r;
  assign ent = ent_r;

endmodule

>>> hdl/dtq_row.sv
module dtq_row
  import dtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  row_cmd_t cmd,
  output entry_t   head,
  output entry_t   tail,
  output logic     any_hit,
  output entry_t   hit_ent
);

  logic   occ  [Capacity];
  entry_t ent  [Capacity];
  logic   hit  [Capacity];
  logic   gt   [Capacity];
  logic   fill [Capacity];
  logic   seen [Capacity+1];
  entry_t hsel [Capacity+1];
  entry_t tsel [Capacity+1];

  // chain of cells, cell 0 holds the head
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    dtq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  ((i == 0) ? cmd.ent : ent[(i == 0) ? 0 : i-1]),
      .left_hit  ((i == 0) ? 1'b0 : seen[i]),
      .left_gt   ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .right_occ ((i == Capacity-1) ? 1'b0 : occ[(i == Capacity-1) ? i : i+1]),
      .right_ent ((i == Capacity-1) ? cmd.ent : ent[(i == Capacity-1) ? i : i+1]),
      .left_fill ((i == 0) ? 1'b1 : fill[(i == 0) ? 0 : i-1]),
      .occ       (occ[i]),
      .ent       (ent[i]),
      .hit       (hit[i]),
      .gt        (gt[i]),
      .fill      (fill[i])
    );
  end

  // first-match and last-occupied selection ripple along the chain
  assign seen[0] = 1'b0;
  assign hsel[0] = '0;
  assign tsel[0] = '0;
  for (genvar i = 0; i < Capacity; i++) begin : g_sel
    assign seen[i+1] = seen[i] || hit[i];
    assign hsel[i+1] = (!seen[i] && hit[i]) ? ent[i] : hsel[i];
    assign tsel[i+1] = occ[i] ? ent[i] : tsel[i];
  end

  assign head    = ent[0];
  assign tail    = tsel[Capacity];
  assign any_hit = seen[Capacity];
  assign hit_ent = hsel[Capacity];

endmodule

>>> hdl/deadline_task_queue_with_undo_unit.sv
// Deadline task queue with undo. Pending tasks sit in a chain of cells kept
// sorted by (year, month, day), a second chain of cells holds completed
// tasks as a stack. Each operation is one transfer in and one result out; an
// item is compared against every cell in parallel and the result registered,
// then the chains shift. The next item is taken once the chains have shifted
// and the result register is free. No clearing pass after reset.
module deadline_task_queue_with_undo_unit
  import dtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [13:0] cfg_min_year,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [15:0] in_task_id,
  input  logic [6:0]  in_deadline_day,
  input  logic [6:0]  in_deadline_month,
  input  logic [13:0] in_deadline_year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_result_id,
  output logic [4:0]  out_result_day,
  output logic [3:0]  out_result_month,
  output logic [13:0] out_result_year,
  output logic [7:0]  out_pending_total,
  output logic [7:0]  out_completed_total
);

  logic [13:0]         min_year_r;
  logic [CntWidth-1:0] pcnt_r, ccnt_r, pcnt_nxt, ccnt_nxt;
  logic [IdWidth-1:0]  next_id_r, next_id_nxt;
  logic                busy_r;
  row_cmd_t            pcmd_r, ccmd_r, pcmd_nxt, ccmd_nxt;
  logic                ovalid_r;
  logic [2:0]          ostat_r, ostat_nxt;
  entry_t              orep_r, orep_nxt;
  logic [7:0]          opt_r, oct_r;
  entry_t              p_head, p_tail, p_hit_ent, c_head, c_tail, c_hit_ent;
  logic                p_any, c_any;
  logic                accept;
  entry_t              key_ent;
  logic                date_ok, leap;
  logic [4:0]          dim;
  logic [26:0]         yprod;
  logic [7:0]          ycent;
  logic [14:0]         yback;
  logic                div100;

  assign in_stall = busy_r || (ovalid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // lookup entry: search key for delete; the rows compare ids in the cycle the item is accepted
  always_comb begin
    key_ent       = '0;
    key_ent.id    = in_task_id[IdWidth-1:0];
  end

  dtq_row u_pend (
    .clk (clk), .rst_n (rst_n), .cmd (busy_r ? pcmd_r : row_cmd_t'({OP_HOLD, key_ent})),
    .head (p_head), .tail (p_tail), .any_hit (p_any), .hit_ent (p_hit_ent)
  );
  dtq_row u_comp (
    .clk (clk), .rst_n (rst_n), .cmd (busy_r ? ccmd_r : row_cmd_t'({OP_HOLD, key_ent})),
    .head (c_head), .tail (c_tail), .any_hit (c_any), .hit_ent (c_hit_ent)
  );

  // date check with the gregorian leap rule
  always_comb begin
    // century count by reciprocal multiply, exact for every 14-bit year
    yprod  = 27'(in_deadline_year) * 27'd5243;
    ycent  = yprod[26:19];
    yback  = 15'(ycent) * 15'd100;
    div100 = (yback == {1'b0, in_deadline_year});
    leap   = (div100 && (ycent[1:0] == 2'd0)) ||
             (!div100 && (in_deadline_year[1:0] == 2'd0));
    case (in_deadline_month)
      7'd4, 7'd6, 7'd9, 7'd11: dim = 5'd30;
      7'd2:                    dim = leap ? 5'd29 : 5'd28;
      default:                 dim = 5'd31;
    endcase
    date_ok = (in_deadline_month >= 7'd1) && (in_deadline_month <= 7'd12) &&
              (in_deadline_year >= min_year_r) && (in_deadline_year <= 14'd9999) &&
              (in_deadline_day >= 7'd1) && (in_deadline_day <= {2'b0, dim});
  end

  // decode one transfer into row commands and the result
  always_comb begin
    entry_t nent;
    nent       = '0;
    nent.id    = next_id_r;
    nent.day   = in_deadline_day[4:0];
    nent.month = in_deadline_month[3:0];
    nent.year  = in_deadline_year;
    pcmd_nxt    = '{op: OP_HOLD, ent: '0};
    ccmd_nxt    = '{op: OP_HOLD, ent: '0};
    ostat_nxt   = ST_OK;
    orep_nxt    = '0;
    pcnt_nxt    = pcnt_r;
    ccnt_nxt    = ccnt_r;
    next_id_nxt = next_id_r;
    case (in_mode)
      MODE_ADD: begin
        if ({1'b0, pcnt_r} + {1'b0, ccnt_r} >= (CntWidth+1)'(Capacity)) begin
          ostat_nxt = ST_FULL;
        end else if (!date_ok) begin
          ostat_nxt = ST_BAD_DATE;
        end else if (next_id_r == '0) begin
          ostat_nxt = ST_NO_IDS;
        end else begin
          orep_nxt    = nent;
          pcmd_nxt    = '{op: OP_INSERT, ent: nent};
          pcnt_nxt    = pcnt_r + 1'b1;
          next_id_nxt = next_id_r + 1'b1;
        end
      end
      MODE_DELETE: begin
        if (pcnt_r == '0 && ccnt_r == '0) begin
          ostat_nxt = ST_EMPTY;
        end else if (in_task_id != '0 && p_any) begin
          orep_nxt = p_hit_ent;
          pcmd_nxt = '{op: OP_DELETE, ent: key_ent};
          pcnt_nxt = pcnt_r - 1'b1;
        end else if (in_task_id != '0 && c_any) begin
          orep_nxt = c_hit_ent;
          ccmd_nxt = '{op: OP_DELETE, ent: key_ent};
          ccnt_nxt = ccnt_r - 1'b1;
        end else begin
          ostat_nxt = ST_NOT_FOUND;
        end
      end
      MODE_COMPLETE: begin
        if (pcnt_r == '0) begin
          ostat_nxt = ST_EMPTY;
        end else begin
          orep_nxt = p_head;
          pcmd_nxt = '{op: OP_POP_FRONT, ent: p_head};
          ccmd_nxt = '{op: OP_PUSH_BACK, ent: p_head};
          pcnt_nxt = pcnt_r - 1'b1;
          ccnt_nxt = ccnt_r + 1'b1;
        end
      end
      MODE_UNDO: begin
        if (ccnt_r == '0) begin
          ostat_nxt = ST_EMPTY;
        end else begin
          orep_nxt = c_tail;
          ccmd_nxt = '{op: OP_POP_BACK, ent: c_tail};
          pcmd_nxt = '{op: OP_INSERT, ent: c_tail};
          pcnt_nxt = pcnt_r + 1'b1;
          ccnt_nxt = ccnt_r - 1'b1;
        end
      end
      MODE_PEEK: begin
        if (pcnt_r == '0) ostat_nxt = ST_EMPTY;
        else orep_nxt = p_head;
      end
      default: ;
    endcase
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r <= 14'd2026;
      pcnt_r     <= '0;
      ccnt_r     <= '0;
      next_id_r  <= IdWidth'(1);
      busy_r     <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      if (cfg_we) min_year_r <= cfg_min_year;
      busy_r <= accept;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (accept) begin
        pcnt_r    <= pcnt_nxt;
        ccnt_r    <= ccnt_nxt;
        next_id_r <= next_id_nxt;
        ovalid_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pcmd_r  <= pcmd_nxt;
      ccmd_r  <= ccmd_nxt;
      ostat_r <= ostat_nxt;
      orep_r  <= orep_nxt;
      opt_r   <= 8'(pcnt_nxt);
      oct_r   <= 8'(ccnt_nxt);
    end
  end

  assign out_valid           = ovalid_r;
  assign out_status          = ostat_r;
  assign out_result_id       = 16'(orep_r.id);
  assign out_result_day      = orep_r.day;
  assign out_result_month    = orep_r.month;
  assign out_result_year     = orep_r.year;
  assign out_pending_total   = opt_r;
  assign out_completed_total = oct_r;

  // the two stores never hold more than the capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, pcnt_r} + {1'b0, ccnt_r}) <= (CntWidth+1)'(Capacity))
    else $error("store count overflow");
  // no transfer while the chains shift
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> in_stall)
    else $error("input taken while busy");
  // an accepted item shows a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_valid)
    else $error("result missing");

endmodule
